FILE: sv/sgf_pkg.sv
// Shared types, field constants and coefficient tables for the GF(q) ALU.
// No dependencies; used by sgf_classify and small_galois_field_alu.
package sgf_pkg;

    localparam int unsigned ORDER_W     = 5;
    localparam int unsigned DEF_MAX_ORDER  = 23;
    localparam int unsigned DEF_DEGREE_CAP = 4;
    localparam int unsigned NUM_EXT     = 4;
    localparam int unsigned NUM_POW     = 15;
    localparam logic [ORDER_W-1:0] RESET_ORDER = 5'd2;

    typedef enum logic {
        FUNC_ADD = 1'b0,
        FUNC_MUL = 1'b1
    } t_func;

    typedef struct packed {
        t_func              func;
        logic [ORDER_W-1:0] operand_a;
        logic [ORDER_W-1:0] operand_b;
    } t_in_word;

    typedef struct packed {
        logic [ORDER_W-1:0] result;
        logic               error;
    } t_out_word;

    typedef struct packed {
        logic       unsupported;
        logic       is_ext;
        logic       char3;
        logic [1:0] fi;
    } t_field_info;

    localparam logic [ORDER_W-1:0] EXT_ORDER  [NUM_EXT] = '{5'd4, 5'd8, 5'd9, 5'd16};
    localparam logic [2:0]         EXT_DEGREE [NUM_EXT] = '{3'd2, 3'd3, 3'd2, 3'd4};

    // Coefficients of alpha^e, two bits per digit, highest power in [7:6].
    localparam logic [7:0] POW_VEC [NUM_EXT][NUM_POW] = '{
        '{8'h10, 8'h40, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h04, 8'h10, 8'h40, 8'h44, 8'h54, 8'h14, 8'h50, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h10, 8'h40, 8'h90, 8'hA0, 8'h20, 8'h80, 8'h60, 8'h50,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h01, 8'h04, 8'h10, 8'h40, 8'h41, 8'h45, 8'h55, 8'h15,
          8'h54, 8'h11, 8'h44, 8'h51, 8'h05, 8'h14, 8'h50}
    };

    function automatic logic [7:0] elem_to_vec(input logic [1:0] fi,
                                               input logic [ORDER_W-1:0] elem);
        logic [ORDER_W-1:0] e;
        e = elem - 5'd1;
        if (elem == '0 || e >= 5'(NUM_POW)) begin
            return 8'h00;
        end
        return POW_VEC[fi][e[3:0]];
    endfunction

    function automatic logic [1:0] digit_add(input logic [1:0] x, input logic [1:0] y,
                                             input logic char3);
        logic [2:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (!char3) begin
            return {1'b0, s[0]};
        end
        if (s >= 3'd3) begin
            s = s - 3'd3;
        end
        return s[1:0];
    endfunction

    function automatic logic [ORDER_W-1:0] vec_to_elem(input logic [1:0] fi,
                                                       input logic [7:0] vec,
                                                       input logic [ORDER_W-1:0] q);
        logic [ORDER_W-1:0] res;
        logic               found;
        res   = '0;
        found = 1'b0;
        for (int e = 0; e < NUM_POW; e++) begin
            if (!found && (5'(e + 1) < q) && POW_VEC[fi][e] == vec) begin
                res   = 5'(e + 1);
                found = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

FILE: sv/sgf_classify.sv
// Field order decoder: prime, supported extension field, or unsupported.
// Depends on sgf_pkg.
module sgf_classify #(
    parameter int unsigned MAX_ORDER  = sgf_pkg::DEF_MAX_ORDER,
    parameter int unsigned DEGREE_CAP = sgf_pkg::DEF_DEGREE_CAP
) (
    input  logic [sgf_pkg::ORDER_W-1:0] i_q,
    output sgf_pkg::t_field_info        o_info
);

    logic prime;
    logic ext_hit;
    logic [1:0] ext_fi;
    logic in_range;

    always_comb begin
        unique case (i_q)
            5'd2, 5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd17,
            5'd19, 5'd23, 5'd29, 5'd31: prime = 1'b1;
            default:                    prime = 1'b0;
        endcase
    end

    always_comb begin
        ext_hit = 1'b0;
        ext_fi  = '0;
        for (int k = 0; k < sgf_pkg::NUM_EXT; k++) begin
            if (!ext_hit && i_q == sgf_pkg::EXT_ORDER[k]
                && 32'(sgf_pkg::EXT_DEGREE[k]) <= DEGREE_CAP) begin
                ext_hit = 1'b1;
                ext_fi  = 2'(k);
            end
        end
    end

    assign in_range = (i_q >= 5'd2) && (32'(i_q) <= MAX_ORDER);

    always_comb begin
        o_info.is_ext      = in_range && !prime && ext_hit;
        o_info.unsupported = !(in_range && (prime || ext_hit));
        o_info.fi          = ext_fi;
        o_info.char3       = (i_q == 5'd9);
    end

endmodule

FILE: sv/small_galois_field_alu.sv
// Top level of the GF(q) add/multiply ALU: config register and 3-stage pipeline.
// A word is registered in r_s1, r_s2 and r_out in turn; one word per cycle while i_out_stall is low.
// Stage 1 multiplies and looks up coefficients, stage 2 and 3 reduce and map back.
// The stall chain lets bubbles collapse while the output word waits.
// Synchronous active-low reset empties the pipeline and sets field order to 2.
// Depends on sgf_pkg and sgf_classify.
module small_galois_field_alu #(
    parameter int unsigned MAX_ORDER  = sgf_pkg::DEF_MAX_ORDER,
    parameter int unsigned DEGREE_CAP = sgf_pkg::DEF_DEGREE_CAP
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sgf_pkg::ORDER_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  sgf_pkg::t_in_word           i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output sgf_pkg::t_out_word          o_out_word
);

    typedef struct packed {
        sgf_pkg::t_func func;
        logic           err;
        logic           is_ext;
        logic           char3;
        logic [1:0]     fi;
        logic [4:0]     q;
        logic [9:0]     prod;
        logic [5:0]     asum;
        logic [4:0]     esum;
        logic           zero_ab;
        logic [7:0]     va;
        logic [7:0]     vb;
    } t_s1;

    typedef struct packed {
        sgf_pkg::t_func func;
        logic           err;
        logic           is_ext;
        logic [1:0]     fi;
        logic [4:0]     q;
        logic [6:0]     prod;
        logic [4:0]     padd;
        logic [4:0]     emul;
        logic [7:0]     vs;
    } t_s2;

    logic [4:0]           r_q;
    sgf_pkg::t_field_info info;
    logic                 r_v1, r_v2, r_v3;
    t_s1                  r_s1, n_s1;
    t_s2                  r_s2, n_s2;
    sgf_pkg::t_out_word   r_out, n_out;
    logic                 rdy1, rdy2, rdy3;

    sgf_classify #(
        .MAX_ORDER  (MAX_ORDER),
        .DEGREE_CAP (DEGREE_CAP)
    ) u_classify (
        .i_q    (r_q),
        .o_info (info)
    );

    assign rdy3       = !r_v3 || !i_out_stall;
    assign rdy2       = !r_v2 || rdy3;
    assign rdy1       = !r_v1 || rdy2;
    assign o_in_stall = !rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= sgf_pkg::RESET_ORDER;
        end else if (i_cfg_we) begin
            r_q <= i_cfg_data;
        end
    end

    // stage 1: range check, product, sums, coefficient lookup
    always_comb begin
        logic [4:0] a, b;
        a = i_in_word.operand_a;
        b = i_in_word.operand_b;
        n_s1.func    = i_in_word.func;
        n_s1.err     = info.unsupported || a >= r_q || b >= r_q;
        n_s1.is_ext  = info.is_ext;
        n_s1.char3   = info.char3;
        n_s1.fi      = info.fi;
        n_s1.q       = r_q;
        n_s1.prod    = {5'd0, a} * {5'd0, b};
        n_s1.asum    = {1'b0, a} + {1'b0, b};
        n_s1.esum    = (a - 5'd1) + (b - 5'd1);
        n_s1.zero_ab = (a == '0) || (b == '0);
        n_s1.va      = sgf_pkg::elem_to_vec(info.fi, a);
        n_s1.vb      = sgf_pkg::elem_to_vec(info.fi, b);
    end

    // stage 2: partial product reduction, sum reductions, coefficient add
    always_comb begin
        logic [9:0] p;
        logic [9:0] t;
        logic [4:0] qm1;
        logic [4:0] es;
        p = r_s1.prod;
        for (int k = 4; k >= 2; k--) begin
            t = 10'(r_s1.q) << k;
            if (p >= t) begin
                p = p - t;
            end
        end
        qm1 = r_s1.q - 5'd1;
        es  = (r_s1.esum >= qm1) ? r_s1.esum - qm1 : r_s1.esum;
        n_s2.func   = r_s1.func;
        n_s2.err    = r_s1.err;
        n_s2.is_ext = r_s1.is_ext;
        n_s2.fi     = r_s1.fi;
        n_s2.q      = r_s1.q;
        n_s2.prod   = p[6:0];
        n_s2.padd   = (r_s1.asum >= {1'b0, r_s1.q}) ? 5'(r_s1.asum - {1'b0, r_s1.q})
                                                    : r_s1.asum[4:0];
        n_s2.emul   = r_s1.zero_ab ? 5'd0 : es + 5'd1;
        for (int d = 0; d < 4; d++) begin
            n_s2.vs[2*d +: 2] = sgf_pkg::digit_add(r_s1.va[2*d +: 2], r_s1.vb[2*d +: 2],
                                                   r_s1.char3);
        end
    end

    // stage 3: final reduction, back to index form, select
    always_comb begin
        logic [6:0] p;
        logic [6:0] t;
        logic [4:0] eadd;
        p = r_s2.prod;
        for (int k = 1; k >= 0; k--) begin
            t = 7'(r_s2.q) << k;
            if (p >= t) begin
                p = p - t;
            end
        end
        eadd = (r_s2.vs == '0) ? 5'd0 : sgf_pkg::vec_to_elem(r_s2.fi, r_s2.vs, r_s2.q);
        n_out.error = r_s2.err;
        priority if (r_s2.err) begin
            n_out.result = '0;
        end else if (!r_s2.is_ext) begin
            n_out.result = (r_s2.func == sgf_pkg::FUNC_MUL) ? p[4:0] : r_s2.padd;
        end else begin
            n_out.result = (r_s2.func == sgf_pkg::FUNC_MUL) ? r_s2.emul : eadd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_in_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) r_s1  <= n_s1;
        if (rdy2) r_s2  <= n_s2;
        if (rdy3) r_out <= n_out;
    end

    assign o_out_valid = r_v3;
    assign o_out_word  = r_out;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.error |-> o_out_word.result == '0)
        else $error("error word with nonzero result");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.error |-> o_out_word.result < r_q)
        else $error("result outside field");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_v1 && r_v2 && r_v3)
        else $error("input stalled with a free stage");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !(r_v3 && i_out_stall) |=> r_v3)
        else $error("stage 2 word lost");

endmodule
